// ----- src/ttt_pkg.sv -----
// Package: shared types and constants of the tick timer table.
`timescale 1ns / 1ps

package ttt_pkg;

  localparam int NumTimersDefault = 8;
  localparam int OpW    = 3;
  localparam int SlotW  = 3;
  localparam int LenW   = 32;
  localparam int ArgW   = 8;
  localparam int DelayW = 16;
  localparam logic [DelayW-1:0] DelayMax = {DelayW{1'b1}};

  typedef enum logic [OpW-1:0] {
    OP_TICK        = 3'd0,
    OP_ARM         = 3'd1,
    OP_DISARM      = 3'd2,
    OP_SET_ARG     = 3'd3,
    OP_START_DELAY = 3'd4
  } opcode_e;

  typedef enum logic {
    EVT_SLOT  = 1'b0,
    EVT_DELAY = 1'b1
  } evt_kind_e;

  typedef struct packed {
    evt_kind_e        kind;
    logic [SlotW-1:0] slot;
    logic [ArgW-1:0]  arg;
  } evt_t;

  // Control from the sequencer into the event buffer.
  typedef struct packed {
    logic push;
    logic flush;
  } buf_ctl_t;

  // Status from the event buffer back to the sequencer.
  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } buf_sts_t;

  typedef struct packed {
    logic [LenW-1:0] period;
    logic [LenW-1:0] count;
  } slot_word_t;

endpackage

// ----- src/ttt_if.sv -----
// Interfaces: command channel and event channel of the tick timer table.
`timescale 1ns / 1ps

interface ttt_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [ttt_pkg::OpW-1:0]    opcode;
  logic [ttt_pkg::SlotW-1:0]  slot;
  logic [ttt_pkg::LenW-1:0]   length_ticks;
  logic                       repeat_req;
  logic [ttt_pkg::ArgW-1:0]   user_arg;

  modport source (output valid, opcode, slot, length_ticks, repeat_req, user_arg,
                  input ready);
  modport sink (input valid, opcode, slot, length_ticks, repeat_req, user_arg,
                output ready);
endinterface

interface ttt_evt_if;
  logic                       valid;
  logic                       ready;
  logic                       event_kind;
  logic [ttt_pkg::SlotW-1:0]  fired_slot;
  logic [ttt_pkg::ArgW-1:0]   event_arg;
  logic                       last;

  modport source (output valid, event_kind, fired_slot, event_arg, last, input ready);
  modport sink (input valid, event_kind, fired_slot, event_arg, last, output ready);
endinterface

// ----- src/ttt_slot_mem.sv -----
// Slot memory: period and count of every timer slot, one write and one read port.
`timescale 1ns / 1ps

module ttt_slot_mem #(
  parameter int NumTimers = ttt_pkg::NumTimersDefault,
  parameter int IdxW      = (NumTimers > 1) ? $clog2(NumTimers) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  ttt_pkg::slot_word_t wdata_i,
  input  logic [IdxW-1:0]     raddr_i,
  output ttt_pkg::slot_word_t rdata_o
);

  ttt_pkg::slot_word_t mem_q [NumTimers];
  ttt_pkg::slot_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ttt_evt_buf.sv -----
// Event buffer: holds one event back until the next one shows whether it was the last.
`timescale 1ns / 1ps

module ttt_evt_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttt_pkg::buf_ctl_t ctl_i,
  input  ttt_pkg::evt_t     evt_i,
  output ttt_pkg::buf_sts_t sts_o,
  ttt_evt_if.source         evt_o
);

  logic          pend_valid_q, pend_valid_d;
  ttt_pkg::evt_t pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  ttt_pkg::evt_t out_q, out_d;
  logic          out_last_q, out_last_d;
  logic          out_free;
  logic          load;

  assign out_free = !out_valid_q || evt_o.ready;
  assign sts_o.push_ok  = !pend_valid_q || out_free;
  assign sts_o.flush_ok = !pend_valid_q || out_free;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    load         = 1'b0;
    if (ctl_i.push) begin
      // A newer event exists, so the held one was not the last.
      if (pend_valid_q) begin
        load       = 1'b1;
        out_d      = pend_q;
        out_last_d = 1'b0;
      end
      pend_d       = evt_i;
      pend_valid_d = 1'b1;
    end else if (ctl_i.flush && pend_valid_q && out_free) begin
      load         = 1'b1;
      out_d        = pend_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (evt_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign evt_o.valid      = out_valid_q;
  assign evt_o.event_kind = out_q.kind;
  assign evt_o.fired_slot = out_q.slot;
  assign evt_o.event_arg  = out_q.arg;
  assign evt_o.last       = out_last_q;

endmodule

// ----- src/tick_timer_table.sv -----
// Top level: command decode and tick sequencer of the tick timer table.
`timescale 1ns / 1ps

// Arm, disarm, set_arg and start_delay commands take effect in the cycle of their
// transfer and produce no events. A tick walks the slot memory one slot per cycle
// while the event buffer can take each event (read one slot while the previous one
// is written back), then checks the delay counter and releases the final event,
// waiting while the event channel stalls. Events leave in slot order with the delay
// event after the slots, and last marks the final event of a tick. The block takes
// the next command once the final event has moved into the output register, even
// while it still waits on the event channel.

module tick_timer_table #(
  parameter int NumTimers = ttt_pkg::NumTimersDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ttt_cmd_if.sink   cmd_i,
  ttt_evt_if.source evt_o
);

  localparam int IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumTimers - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PRIME = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DELAY = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic [NumTimers-1:0]         active_q, active_d;
  logic [NumTimers-1:0]         repeat_q, repeat_d;
  logic [ttt_pkg::ArgW-1:0]     arg_q [NumTimers];
  logic                         dly_en_q, dly_en_d;
  logic [ttt_pkg::DelayW-1:0]   dly_cnt_q, dly_cnt_d;
  logic [ttt_pkg::DelayW-1:0]   dly_tgt_q, dly_tgt_d;

  logic                         mem_we;
  logic [IdxW-1:0]              mem_waddr;
  ttt_pkg::slot_word_t          mem_wdata;
  logic [IdxW-1:0]              mem_raddr;
  ttt_pkg::slot_word_t          mem_rdata;

  ttt_pkg::buf_ctl_t            buf_ctl;
  ttt_pkg::buf_sts_t            buf_sts;
  ttt_pkg::evt_t                evt;

  logic                         cmd_xfer;
  logic                         slot_ok;
  logic [IdxW+ttt_pkg::SlotW-1:0] slot_ext;
  logic [IdxW-1:0]              cmd_idx;
  logic [IdxW+ttt_pkg::SlotW-1:0] idx_ext;
  logic [ttt_pkg::LenW-1:0]     cnt_inc;
  logic                         slot_hit;
  logic [ttt_pkg::DelayW-1:0]   dly_inc;
  logic                         dly_hit;
  logic                         arg_we;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;

  assign slot_ext = {{IdxW{1'b0}}, cmd_i.slot};
  assign cmd_idx  = slot_ext[IdxW-1:0];
  assign slot_ok  = (32'(cmd_i.slot) < NumTimers);

  assign idx_ext  = {{ttt_pkg::SlotW{1'b0}}, idx_q};
  assign cnt_inc  = mem_rdata.count + ttt_pkg::LenW'(1);
  assign slot_hit = active_q[idx_q] && (cnt_inc >= mem_rdata.period);
  assign dly_inc  = dly_cnt_q + ttt_pkg::DelayW'(1);
  assign dly_hit  = dly_inc >= dly_tgt_q;

  assign arg_we = cmd_xfer && slot_ok && (cmd_i.opcode == ttt_pkg::OP_SET_ARG);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    active_d  = active_q;
    repeat_d  = repeat_q;
    dly_en_d  = dly_en_q;
    dly_cnt_d = dly_cnt_q;
    dly_tgt_d = dly_tgt_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = mem_rdata;
    mem_raddr = idx_q;
    buf_ctl   = '0;
    evt.kind  = ttt_pkg::EVT_SLOT;
    evt.slot  = idx_ext[ttt_pkg::SlotW-1:0];
    evt.arg   = arg_q[idx_q];

    case (state_q)
      ST_IDLE: begin
        if (cmd_xfer) begin
          case (cmd_i.opcode)
            ttt_pkg::OP_TICK: begin
              idx_d   = '0;
              state_d = ST_PRIME;
            end
            ttt_pkg::OP_ARM: begin
              if (slot_ok) begin
                mem_we           = 1'b1;
                mem_waddr        = cmd_idx;
                mem_wdata.period = cmd_i.length_ticks;
                mem_wdata.count  = '0;
                repeat_d[cmd_idx] = cmd_i.repeat_req;
                active_d[cmd_idx] = 1'b1;
              end
            end
            ttt_pkg::OP_DISARM: begin
              if (slot_ok) begin
                active_d[cmd_idx] = 1'b0;
              end
            end
            ttt_pkg::OP_START_DELAY: begin
              dly_tgt_d = (cmd_i.length_ticks > ttt_pkg::LenW'(ttt_pkg::DelayMax))
                          ? ttt_pkg::DelayMax
                          : cmd_i.length_ticks[ttt_pkg::DelayW-1:0];
              dly_cnt_d = '0;
              dly_en_d  = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ST_PRIME: begin
        state_d = ST_SCAN;
      end

      ST_SCAN: begin
        // Hold the slot and reread it while the buffer cannot take its event.
        if (!(slot_hit && !buf_sts.push_ok)) begin
          if (active_q[idx_q]) begin
            mem_we          = 1'b1;
            mem_wdata.count = (slot_hit && repeat_q[idx_q]) ? '0 : cnt_inc;
            if (slot_hit && !repeat_q[idx_q]) begin
              active_d[idx_q] = 1'b0;
            end
          end
          buf_ctl.push = slot_hit;
          mem_raddr    = idx_q + IdxW'(1);
          if (idx_q == LastIdx) begin
            state_d = ST_DELAY;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end

      ST_DELAY: begin
        evt.kind = ttt_pkg::EVT_DELAY;
        evt.slot = '0;
        evt.arg  = '0;
        if (!dly_en_q) begin
          state_d = ST_FLUSH;
        end else if (!(dly_hit && !buf_sts.push_ok)) begin
          dly_cnt_d    = dly_inc;
          dly_en_d     = !dly_hit;
          buf_ctl.push = dly_hit;
          state_d      = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        buf_ctl.flush = 1'b1;
        if (buf_sts.flush_ok) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      active_q  <= '0;
      repeat_q  <= '0;
      dly_en_q  <= 1'b0;
      dly_cnt_q <= '0;
      dly_tgt_q <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      active_q  <= active_d;
      repeat_q  <= repeat_d;
      dly_en_q  <= dly_en_d;
      dly_cnt_q <= dly_cnt_d;
      dly_tgt_q <= dly_tgt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTimers; i++) begin
        arg_q[i] <= '0;
      end
    end else if (arg_we) begin
      arg_q[cmd_idx] <= cmd_i.user_arg;
    end
  end

  ttt_slot_mem #(
    .NumTimers (NumTimers),
    .IdxW      (IdxW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ttt_evt_buf u_evt_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (buf_ctl),
    .evt_i  (evt),
    .sts_o  (buf_sts),
    .evt_o  (evt_o)
  );

endmodule
